/* hdl/ecsm_pkg.sv */
// ----------------------------------------------------------------------------
// ecsm_pkg
// Shared types and constants of the elliptic-curve scalar multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecsm_pkg;

    localparam int W     = 64;
    localparam int CNT_W = $clog2(W);

    // configuration register indexes
    localparam logic CFG_CURVE_A = 1'b0;
    localparam logic CFG_MODULUS = 1'b1;

    typedef struct packed {
        logic [W-1:0] scalar;
        logic [W-1:0] px;
        logic [W-1:0] py;
    } t_in_item;

    typedef struct packed {
        logic [W-1:0] qx;
        logic [W-1:0] qy;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        t_op          op;
        logic [W-1:0] a;
        logic [W-1:0] b;
    } t_arith_req;

    typedef struct packed {
        logic         done;
        logic [W-1:0] res;
        logic [W-1:0] rem;
    } t_arith_rsp;

    typedef enum logic {
        A_IDLE,
        A_RUN
    } t_ast;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RED_A,
        S_RED_X,
        S_RED_Y,
        S_CHK,
        S_D_SQ,
        S_D_N1,
        S_D_N2,
        S_D_N3,
        S_D_DEN,
        S_A_NUM,
        S_A_DEN,
        S_INV0,
        S_INV_CHK,
        S_INV_DIV,
        S_INV_MUL,
        S_INV_SUB,
        S_SLOPE,
        S_X_A,
        S_X_B,
        S_X_C,
        S_Y_A,
        S_Y_B,
        S_Y_C,
        S_NEXT,
        S_DONE
    } t_sst;

endpackage

`default_nettype wire

/* hdl/ecsm_arith.sv */
// ----------------------------------------------------------------------------
// ecsm_arith
// Shared modular arithmetic unit: add, subtract, bit-serial multiply, and
// bit-serial integer divide giving quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsm_arith (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire ecsm_pkg::t_arith_req  i_req,
    input  wire logic [ecsm_pkg::W-1:0] i_m,
    output ecsm_pkg::t_arith_rsp       o_rsp
);

    localparam int W = ecsm_pkg::W;

    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                             input logic [W-1:0] y,
                                             input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    ecsm_pkg::t_ast r_state, n_state;
    ecsm_pkg::t_op  r_op;
    logic [W-1:0]   r_acc;
    logic [W-1:0]   r_x;
    logic [W-1:0]   r_y;
    logic [ecsm_pkg::CNT_W-1:0] r_cnt;
    logic           r_ph;
    logic           r_done;
    logic           w_last;
    logic [W:0]     w_trial;
    logic           w_qbit;

    assign w_trial = {r_acc, r_y[W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_x});
    assign w_last  = (r_cnt == '0) && ((r_op == ecsm_pkg::OP_DIV) || r_ph);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecsm_pkg::A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ecsm_pkg::A_IDLE: begin
                if (i_start && (i_req.op == ecsm_pkg::OP_MUL
                                || i_req.op == ecsm_pkg::OP_DIV)) begin
                    n_state = ecsm_pkg::A_RUN;
                end
            end
            ecsm_pkg::A_RUN: begin
                if (w_last) begin
                    n_state = ecsm_pkg::A_IDLE;
                end
            end
            default: n_state = ecsm_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ((r_state == ecsm_pkg::A_IDLE) && i_start
                       && (i_req.op == ecsm_pkg::OP_ADD || i_req.op == ecsm_pkg::OP_SUB))
                      || ((r_state == ecsm_pkg::A_RUN) && w_last);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ecsm_pkg::A_IDLE: begin
                if (i_start) begin
                    r_op  <= i_req.op;
                    r_cnt <= ecsm_pkg::CNT_W'(W - 1);
                    r_ph  <= 1'b0;
                    case (i_req.op)
                        ecsm_pkg::OP_ADD: r_acc <= add_mod(i_req.a, i_req.b, i_m);
                        // wraps to a + (m - b) when a < b
                        ecsm_pkg::OP_SUB: r_acc <= (i_req.a >= i_req.b) ?
                                                   (i_req.a - i_req.b) :
                                                   (i_req.a - i_req.b + i_m);
                        ecsm_pkg::OP_MUL: begin
                            r_acc <= '0;
                            r_x   <= i_req.a;
                            r_y   <= i_req.b;
                        end
                        ecsm_pkg::OP_DIV: begin
                            r_acc <= '0;
                            r_x   <= i_req.b;
                            r_y   <= i_req.a;
                        end
                        default: r_acc <= '0;
                    endcase
                end
            end
            ecsm_pkg::A_RUN: begin
                if (r_op == ecsm_pkg::OP_DIV) begin
                    // restoring step: shift in a dividend bit, subtract if it fits
                    r_acc <= w_qbit ? W'(w_trial - {1'b0, r_x}) : w_trial[W-1:0];
                    r_y   <= {r_y[W-2:0], w_qbit};
                    r_cnt <= r_cnt - 1'b1;
                end else if (!r_ph) begin
                    r_acc <= add_mod(r_acc, r_acc, i_m);
                    r_ph  <= 1'b1;
                end else begin
                    if (r_y[W-1]) begin
                        r_acc <= add_mod(r_acc, r_x, i_m);
                    end
                    r_y   <= {r_y[W-2:0], 1'b0};
                    r_ph  <= 1'b0;
                    r_cnt <= r_cnt - 1'b1;
                end
            end
            default: r_ph <= 1'b0;
        endcase
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = (r_op == ecsm_pkg::OP_DIV) ? r_y : r_acc;
    assign o_rsp.rem  = r_acc;

endmodule

`default_nettype wire

/* hdl/ecsm_seq.sv */
// ----------------------------------------------------------------------------
// ecsm_seq
// Sequencer for double-and-add: steps the point formulas and the Euclid
// inversion through the shared arithmetic unit and holds the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsm_seq (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire ecsm_pkg::t_in_item     i_item,
    input  wire logic [ecsm_pkg::W-1:0] i_curve_a,
    input  wire logic [ecsm_pkg::W-1:0] i_modulus,
    input  wire ecsm_pkg::t_arith_rsp   i_rsp,
    output ecsm_pkg::t_arith_req        o_req,
    output logic                        o_req_start,
    output logic                        o_busy,
    output logic                        o_done,
    output ecsm_pkg::t_out_item         o_result
);

    localparam int W = ecsm_pkg::W;

    ecsm_pkg::t_sst r_state, n_state;
    logic         r_wait;
    logic         r_dbl;
    logic [ecsm_pkg::CNT_W-1:0] r_bit;
    logic [W-1:0] r_k, r_px, r_py, r_a, r_qx, r_qy;
    logic [W-1:0] r_num, r_den, r_t, r_s, r_x3;
    logic [W-1:0] r_r0, r_r1, r_t0, r_t1;
    logic [W-1:0] w_x2, w_y2;
    logic         w_op;

    assign w_x2 = r_dbl ? r_qx : r_px;
    assign w_y2 = r_dbl ? r_qy : r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ecsm_pkg::S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_req_start) begin
                r_wait <= 1'b1;
            end else if (i_rsp.done) begin
                r_wait <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        w_op    = 1'b1;
        o_req   = '{op: ecsm_pkg::OP_ADD, a: '0, b: '0};
        case (r_state)
            ecsm_pkg::S_IDLE: begin
                w_op = 1'b0;
                if (i_start) begin
                    n_state = (i_modulus[W-1:1] == '0) ? ecsm_pkg::S_DONE
                                                       : ecsm_pkg::S_RED_A;
                end
            end
            ecsm_pkg::S_RED_A: begin
                o_req = '{op: ecsm_pkg::OP_DIV, a: i_curve_a, b: i_modulus};
                if (i_rsp.done) n_state = ecsm_pkg::S_RED_X;
            end
            ecsm_pkg::S_RED_X: begin
                o_req = '{op: ecsm_pkg::OP_DIV, a: r_px, b: i_modulus};
                if (i_rsp.done) n_state = ecsm_pkg::S_RED_Y;
            end
            ecsm_pkg::S_RED_Y: begin
                o_req = '{op: ecsm_pkg::OP_DIV, a: r_py, b: i_modulus};
                if (i_rsp.done) n_state = ecsm_pkg::S_CHK;
            end
            ecsm_pkg::S_CHK: begin
                w_op = 1'b0;
                if ((r_qx == '0 && r_qy == '0) || (w_x2 == '0 && w_y2 == '0)) begin
                    n_state = ecsm_pkg::S_NEXT;
                end else if (r_qx == w_x2 && r_qy == w_y2) begin
                    n_state = ecsm_pkg::S_D_SQ;
                end else begin
                    n_state = ecsm_pkg::S_A_NUM;
                end
            end
            ecsm_pkg::S_D_SQ: begin
                o_req = '{op: ecsm_pkg::OP_MUL, a: r_qx, b: r_qx};
                if (i_rsp.done) n_state = ecsm_pkg::S_D_N1;
            end
            ecsm_pkg::S_D_N1: begin
                o_req = '{op: ecsm_pkg::OP_ADD, a: r_t, b: r_t};
                if (i_rsp.done) n_state = ecsm_pkg::S_D_N2;
            end
            ecsm_pkg::S_D_N2: begin
                o_req = '{op: ecsm_pkg::OP_ADD, a: r_num, b: r_t};
                if (i_rsp.done) n_state = ecsm_pkg::S_D_N3;
            end
            ecsm_pkg::S_D_N3: begin
                o_req = '{op: ecsm_pkg::OP_ADD, a: r_num, b: r_a};
                if (i_rsp.done) n_state = ecsm_pkg::S_D_DEN;
            end
            ecsm_pkg::S_D_DEN: begin
                o_req = '{op: ecsm_pkg::OP_ADD, a: r_qy, b: r_qy};
                if (i_rsp.done) n_state = ecsm_pkg::S_INV0;
            end
            ecsm_pkg::S_A_NUM: begin
                o_req = '{op: ecsm_pkg::OP_SUB, a: w_y2, b: r_qy};
                if (i_rsp.done) n_state = ecsm_pkg::S_A_DEN;
            end
            ecsm_pkg::S_A_DEN: begin
                o_req = '{op: ecsm_pkg::OP_SUB, a: w_x2, b: r_qx};
                if (i_rsp.done) n_state = ecsm_pkg::S_INV0;
            end
            ecsm_pkg::S_INV0: begin
                w_op    = 1'b0;
                n_state = (r_den == '0) ? ecsm_pkg::S_NEXT : ecsm_pkg::S_INV_CHK;
            end
            ecsm_pkg::S_INV_CHK: begin
                w_op = 1'b0;
                if (r_r1 != '0) begin
                    n_state = ecsm_pkg::S_INV_DIV;
                end else if (r_r0 == W'(1)) begin
                    n_state = ecsm_pkg::S_SLOPE;
                end else begin
                    n_state = ecsm_pkg::S_NEXT;
                end
            end
            ecsm_pkg::S_INV_DIV: begin
                o_req = '{op: ecsm_pkg::OP_DIV, a: r_r0, b: r_r1};
                if (i_rsp.done) n_state = ecsm_pkg::S_INV_MUL;
            end
            ecsm_pkg::S_INV_MUL: begin
                o_req = '{op: ecsm_pkg::OP_MUL, a: r_t, b: r_t1};
                if (i_rsp.done) n_state = ecsm_pkg::S_INV_SUB;
            end
            ecsm_pkg::S_INV_SUB: begin
                o_req = '{op: ecsm_pkg::OP_SUB, a: r_t0, b: r_t};
                if (i_rsp.done) n_state = ecsm_pkg::S_INV_CHK;
            end
            ecsm_pkg::S_SLOPE: begin
                o_req = '{op: ecsm_pkg::OP_MUL, a: r_t0, b: r_num};
                if (i_rsp.done) n_state = ecsm_pkg::S_X_A;
            end
            ecsm_pkg::S_X_A: begin
                o_req = '{op: ecsm_pkg::OP_MUL, a: r_s, b: r_s};
                if (i_rsp.done) n_state = ecsm_pkg::S_X_B;
            end
            ecsm_pkg::S_X_B: begin
                o_req = '{op: ecsm_pkg::OP_SUB, a: r_t, b: r_qx};
                if (i_rsp.done) n_state = ecsm_pkg::S_X_C;
            end
            ecsm_pkg::S_X_C: begin
                o_req = '{op: ecsm_pkg::OP_SUB, a: r_t, b: w_x2};
                if (i_rsp.done) n_state = ecsm_pkg::S_Y_A;
            end
            ecsm_pkg::S_Y_A: begin
                o_req = '{op: ecsm_pkg::OP_SUB, a: r_qx, b: r_x3};
                if (i_rsp.done) n_state = ecsm_pkg::S_Y_B;
            end
            ecsm_pkg::S_Y_B: begin
                o_req = '{op: ecsm_pkg::OP_MUL, a: r_s, b: r_t};
                if (i_rsp.done) n_state = ecsm_pkg::S_Y_C;
            end
            ecsm_pkg::S_Y_C: begin
                o_req = '{op: ecsm_pkg::OP_SUB, a: r_t, b: r_qy};
                if (i_rsp.done) n_state = ecsm_pkg::S_NEXT;
            end
            ecsm_pkg::S_NEXT: begin
                w_op = 1'b0;
                if ((r_dbl && r_k[r_bit]) || r_bit != '0) begin
                    n_state = ecsm_pkg::S_CHK;
                end else begin
                    n_state = ecsm_pkg::S_DONE;
                end
            end
            ecsm_pkg::S_DONE: begin
                w_op    = 1'b0;
                n_state = ecsm_pkg::S_IDLE;
            end
            default: begin
                w_op    = 1'b0;
                n_state = ecsm_pkg::S_IDLE;
            end
        endcase
    end

    assign o_req_start = w_op && !r_wait;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ecsm_pkg::S_IDLE: begin
                if (i_start) begin
                    r_k  <= i_item.scalar;
                    r_px <= i_item.px;
                    r_py <= i_item.py;
                    r_qx <= '0;
                    r_qy <= '0;
                end
            end
            ecsm_pkg::S_RED_A: if (i_rsp.done) r_a  <= i_rsp.rem;
            ecsm_pkg::S_RED_X: if (i_rsp.done) r_px <= i_rsp.rem;
            ecsm_pkg::S_RED_Y: begin
                if (i_rsp.done) begin
                    r_py  <= i_rsp.rem;
                    r_bit <= ecsm_pkg::CNT_W'(W - 1);
                    r_dbl <= 1'b1;
                end
            end
            ecsm_pkg::S_CHK: begin
                // infinity plus P gives P
                if (r_qx == '0 && r_qy == '0) begin
                    r_qx <= w_x2;
                    r_qy <= w_y2;
                end
            end
            ecsm_pkg::S_D_SQ:  if (i_rsp.done) r_t   <= i_rsp.res;
            ecsm_pkg::S_D_N1:  if (i_rsp.done) r_num <= i_rsp.res;
            ecsm_pkg::S_D_N2:  if (i_rsp.done) r_num <= i_rsp.res;
            ecsm_pkg::S_D_N3:  if (i_rsp.done) r_num <= i_rsp.res;
            ecsm_pkg::S_D_DEN: if (i_rsp.done) r_den <= i_rsp.res;
            ecsm_pkg::S_A_NUM: if (i_rsp.done) r_num <= i_rsp.res;
            ecsm_pkg::S_A_DEN: if (i_rsp.done) r_den <= i_rsp.res;
            ecsm_pkg::S_INV0: begin
                if (r_den == '0) begin
                    r_qx <= '0;
                    r_qy <= '0;
                end
                r_r0 <= i_modulus;
                r_r1 <= r_den;
                r_t0 <= '0;
                r_t1 <= W'(1);
            end
            ecsm_pkg::S_INV_CHK: begin
                // no inverse: denominator shares a factor with the modulus
                if (r_r1 == '0 && r_r0 != W'(1)) begin
                    r_qx <= '0;
                    r_qy <= '0;
                end
            end
            ecsm_pkg::S_INV_DIV: begin
                if (i_rsp.done) begin
                    r_t  <= (i_rsp.res == i_modulus) ? '0 : i_rsp.res;
                    r_r0 <= r_r1;
                    r_r1 <= i_rsp.rem;
                end
            end
            ecsm_pkg::S_INV_MUL: if (i_rsp.done) r_t <= i_rsp.res;
            ecsm_pkg::S_INV_SUB: begin
                if (i_rsp.done) begin
                    r_t0 <= r_t1;
                    r_t1 <= i_rsp.res;
                end
            end
            ecsm_pkg::S_SLOPE: if (i_rsp.done) r_s  <= i_rsp.res;
            ecsm_pkg::S_X_A:   if (i_rsp.done) r_t  <= i_rsp.res;
            ecsm_pkg::S_X_B:   if (i_rsp.done) r_t  <= i_rsp.res;
            ecsm_pkg::S_X_C:   if (i_rsp.done) r_x3 <= i_rsp.res;
            ecsm_pkg::S_Y_A:   if (i_rsp.done) r_t  <= i_rsp.res;
            ecsm_pkg::S_Y_B:   if (i_rsp.done) r_t  <= i_rsp.res;
            ecsm_pkg::S_Y_C: begin
                if (i_rsp.done) begin
                    r_qx <= r_x3;
                    r_qy <= i_rsp.res;
                end
            end
            ecsm_pkg::S_NEXT: begin
                if (r_dbl && r_k[r_bit]) begin
                    r_dbl <= 1'b0;
                end else if (r_bit != '0) begin
                    r_bit <= r_bit - 1'b1;
                    r_dbl <= 1'b1;
                end
            end
            default: r_dbl <= r_dbl;
        endcase
    end

    assign o_busy      = (r_state != ecsm_pkg::S_IDLE);
    assign o_done      = (r_state == ecsm_pkg::S_DONE);
    assign o_result.qx = r_qx;
    assign o_result.qy = r_qy;

endmodule

`default_nettype wire

/* hdl/ec_scalar_multiply_unit.sv */
// ----------------------------------------------------------------------------
// ec_scalar_multiply_unit
// Latency: data dependent. The operands are first reduced, then each scalar
//   bit costs one doubling and, for a one bit, one addition, each followed by
//   the Euclid steps of its inversion; the result then passes through S_DONE
//   and the output register to the strobe. Throughput: one word at a time,
//   set by the single bit-serial arithmetic unit; no receiver stall.
// Reset: synchronous, active low; curve_a returns to 1, modulus to 17.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_scalar_multiply_unit (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire ecsm_pkg::t_in_item     i_item,
    output logic                        o_strobe,
    output ecsm_pkg::t_out_item         o_result,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_idx,
    input  wire logic [ecsm_pkg::W-1:0] i_cfg_data
);

    localparam int W = ecsm_pkg::W;

    logic [W-1:0]          r_curve_a;
    logic [W-1:0]          r_modulus;
    logic                  r_strobe;
    ecsm_pkg::t_out_item   r_result;

    logic                  w_accept;
    logic                  w_busy;
    logic                  w_done;
    logic                  w_req_start;
    ecsm_pkg::t_arith_req  w_req;
    ecsm_pkg::t_arith_rsp  w_rsp;
    ecsm_pkg::t_out_item   w_result;

    // take a word only while the sequencer is idle
    assign w_accept = start && !w_busy;

    // configuration writes: the user must write the port only while idle; not enforced here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_a <= W'(1);
            r_modulus <= W'(17);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ecsm_pkg::CFG_CURVE_A: r_curve_a <= i_cfg_data;
                ecsm_pkg::CFG_MODULUS: r_modulus <= i_cfg_data;
                default:               r_modulus <= r_modulus;
            endcase
        end
    end

    ecsm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_item      (i_item),
        .i_curve_a   (r_curve_a),
        .i_modulus   (r_modulus),
        .i_rsp       (w_rsp),
        .o_req       (w_req),
        .o_req_start (w_req_start),
        .o_busy      (w_busy),
        .o_done      (w_done),
        .o_result    (w_result)
    );

    // one shared unit does every add, subtract, product and division
    ecsm_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_req_start),
        .i_req   (w_req),
        .i_m     (r_modulus),
        .o_rsp   (w_rsp)
    );

    // output register: strobe the result for exactly one cycle; the word holds until the next result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_result <= w_result;
        end
    end

    assign busy     = w_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted word did not raise busy");

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a word in progress");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_op_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_start |-> !w_busy == 1'b0)
        else $error("arithmetic request while sequencer idle");
`endif

endmodule

`default_nettype wire

/* tb/ecsm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecsm_checker
// Watches the command, result and register ports of the scalar multiply unit,
// predicts k*P for every accepted word and compares the returned point.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsm_checker (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic                   i_busy,
    input  wire ecsm_pkg::t_in_item     i_item,
    input  wire logic                   i_strobe,
    input  wire ecsm_pkg::t_out_item    i_result,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_idx,
    input  wire logic [ecsm_pkg::W-1:0] i_cfg_data,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_products
);
    import ecsm_pkg::*;

    typedef logic [W-1:0] t_res;

    t_res      coef_a;
    t_res      field_p;
    t_out_item product_q[$];

    function automatic t_res fadd(t_res x, t_res y, t_res m);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[W-1:0];
    endfunction

    function automatic t_res fsub(t_res x, t_res y, t_res m);
        return (x >= y) ? x - y : x + (m - y);
    endfunction

    function automatic t_res fmul(t_res x, t_res y, t_res m);
        logic [2*W-1:0] p;
        p = {{W{1'b0}}, x} * {{W{1'b0}}, y};
        return t_res'(p % {{W{1'b0}}, m});
    endfunction

    // extended Euclid; returns 0 when d has no inverse
    function automatic logic finv(t_res d, t_res m, output t_res inv);
        t_res r0, r1, r2, t0, t1, t2, q;
        r0 = m; r1 = d; t0 = '0; t1 = 1;
        inv = '0;
        while (r1 != 0) begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            t2 = fsub(t0, fmul(q % m, t1, m), m);
            r0 = r1; r1 = r2;
            t0 = t1; t1 = t2;
        end
        if (r0 != 1) return 1'b0;
        inv = t0;
        return 1'b1;
    endfunction

    function automatic t_out_item pt_sum(t_out_item p1, t_out_item p2, t_res a, t_res m);
        t_out_item r;
        t_res      num, den, inv, s, sq;
        r = '0;
        if (p1.qx == 0 && p1.qy == 0) return p2;
        if (p2.qx == 0 && p2.qy == 0) return p1;
        if (p1 == p2) begin
            sq  = fmul(p1.qx, p1.qx, m);
            num = fadd(fadd(fadd(sq, sq, m), sq, m), a, m);
            den = fadd(p1.qy, p1.qy, m);
        end else begin
            num = fsub(p2.qy, p1.qy, m);
            den = fsub(p2.qx, p1.qx, m);
        end
        // vertical line or no inverse: infinity
        if (den == 0 || !finv(den, m, inv)) return r;
        s    = fmul(inv, num, m);
        r.qx = fsub(fsub(fmul(s, s, m), p1.qx, m), p2.qx, m);
        r.qy = fsub(fmul(s, fsub(p1.qx, r.qx, m), m), p1.qy, m);
        return r;
    endfunction

    function automatic t_out_item scalar_mult(t_in_item it, t_res a_reg, t_res m);
        t_out_item q, p;
        t_res      a;
        q = '0;
        if (m < 2) return q;
        a    = a_reg % m;
        p.qx = it.px % m;
        p.qy = it.py % m;
        for (int i = W - 1; i >= 0; i--) begin
            q = pt_sum(q, q, a, m);
            if (it.scalar[i]) q = pt_sum(q, p, a, m);
        end
        return q;
    endfunction

    assign o_pending = product_q.size();

    always_ff @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            coef_a     <= 1;
            field_p    <= 17;
            o_errors   <= 0;
            o_products <= 0;
            product_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CURVE_A) coef_a <= i_cfg_data;
                else                          field_p <= i_cfg_data;
            end
            if (i_start && !i_busy)
                product_q.push_back(scalar_mult(i_item, coef_a, field_p));
            if (i_strobe) begin
                o_products <= o_products + 1;
                if (product_q.size() == 0) begin
                    $error("unexpected result word qx=%h qy=%h", i_result.qx, i_result.qy);
                    o_errors <= o_errors + 1;
                end else begin
                    want = product_q.pop_front();
                    if (want.qx !== i_result.qx) begin
                        $error("qx mismatch: expected %h actual %h", want.qx, i_result.qx);
                        o_errors <= o_errors + 1;
                    end else if (want.qy !== i_result.qy) begin
                        $error("qy mismatch: expected %h actual %h", want.qy, i_result.qy);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the scalar multiply unit: directed corner words,
// then random phases over several curve settings and idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import ecsm_pkg::*;

    localparam logic [W-1:0] ALL_ONES  = '1;
    localparam logic [W-1:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;
    // watchdog limit, sized for the worst word with a wide modulus
    localparam int           WDOG_MAX  = 6_000_000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_result;
    logic      i_cfg_we;
    logic      i_cfg_idx;
    logic [W-1:0] i_cfg_data;

    int n_errors;
    int n_pending;
    int n_products;
    int n_sent;
    int idle_pct;
    int quiet_cycles;
    logic [W-1:0] cur_mod;

    ec_scalar_multiply_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ecsm_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (i_item),
        .i_strobe   (o_strobe),
        .i_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (n_errors),
        .o_pending  (n_pending),
        .o_products (n_products)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: count cycles in which neither a command nor a result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Hold start with the word until the unit takes it, then optionally
    // drop start for a random gap according to the current idle ratio.
    task automatic send_word(logic [W-1:0] k, logic [W-1:0] x, logic [W-1:0] y);
        int gap;
        start  <= 1'b1;
        i_item <= '{scalar: k, px: x, py: y};
        do @(posedge i_clk); while (busy);
        n_sent++;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain every outstanding product, then let the unit settle to idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [W-1:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_MODULUS) cur_mod = val;
    endtask

    // Random word: coordinates mostly reduced, sometimes raw 64-bit values.
    // Full-width scalars only with a tiny field, where the walk stays cheap.
    task automatic send_random();
        logic [W-1:0] k, x, y;
        if (cur_mod < 300 && $urandom_range(7) == 0) k = rand64();
        else                                         k = W'($urandom_range(0, 63));
        if ($urandom_range(7) == 0) begin
            x = rand64();
            y = rand64();
        end else begin
            x = rand64() % cur_mod;
            y = rand64() % cur_mod;
        end
        send_word(k, x, y);
    endtask

    initial begin
        logic [W-1:0] moduli[8];
        moduli = '{17, 97, 251, 1009, 65521, 15, 221, 2};
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_CURVE_A;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        idle_pct   = 0;
        n_sent     = 0;
        cur_mod    = 17;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners on the reset curve
        send_word(0, 5, 1);                      // scalar zero
        send_word(1, 5, 1);
        send_word(2, 7, 0);                      // doubling with y = 0
        send_word(9, 0, 0);                      // base point at infinity
        send_word(3, ALL_ONES, ALL_ONES);        // unreduced coordinates
        send_word(64'h8000_0000_0000_0000, 3, 4);
        send_word(ALL_ONES, 2, 9);
        send_word(13, 17, 34);                   // reduces to infinity

        // tiny moduli: 0 and 1 give infinity for everything, then modulus 2
        write_reg(CFG_MODULUS, 0);
        send_word(5, 3, 4);
        write_reg(CFG_MODULUS, 1);
        send_word(ALL_ONES, ALL_ONES, 1);
        write_reg(CFG_MODULUS, 2);
        send_word(7, 1, 1);
        send_word(6, 0, 1);

        // wide field extremes, curve_a at its edges
        write_reg(CFG_CURVE_A, ALL_ONES);
        write_reg(CFG_MODULUS, BIG_PRIME);
        send_word(3, rand64() % BIG_PRIME, rand64() % BIG_PRIME);
        send_word(2, ALL_ONES, ALL_ONES);
        write_reg(CFG_CURVE_A, 0);
        write_reg(CFG_MODULUS, ALL_ONES);        // composite: inverse may fail
        send_word(5, rand64(), rand64());
        send_word(4, 6, ALL_ONES - 1);

        // random phases: no idling, heavy idling, heavy again, light
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 0) ? 0 : (ph == 3) ? 29 : 68;
            write_reg(CFG_CURVE_A, (ph == 1) ? ALL_ONES : rand64());
            write_reg(CFG_MODULUS, moduli[3'($urandom_range(7))]);
            for (int j = 0; j < 22; j++) begin
                if (j == 11 && ph == 2) drain();   // hold off until all products return
                if (j == 11 && ph != 2) write_reg(CFG_MODULUS, moduli[3'($urandom_range(7))]);
                send_random();
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d commands and %0d products over tiny, small, composite and",
                 n_sent, n_products);
        $display("64-bit moduli, with curve_a at both extremes and idle ratios 0/29/68.");
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
